FILE: rtl/gso_pkg.sv
// Shared types, constants and the quarter-wave sine function for the glide sine oscillator.
`timescale 1ns / 1ps
package gso_pkg;

	localparam int PHASE_BITS      = 32;
	localparam int SINE_TABLE_BITS = 10;
	localparam int FREQ_FRAC_BITS  = 8;

	localparam int HZ_W     = 15;
	localparam int INCR_W   = 16;
	localparam int SAMPLE_W = 15;
	localparam int MAG_W    = 14;
	localparam int TDATA_W  = 16;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [MAG_W-1:0] AMPLITUDE = 14'd10000;

	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_FREQ = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INCR   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RECTIFY      = 8'd2;

	localparam logic [HZ_W-1:0]   RST_INITIAL_FREQ = 15'd440;
	localparam logic [INCR_W-1:0] RST_PHASE_INCR   = 16'd48696;

	// commands from controller to datapath, one step per flag
	typedef struct packed {
		logic accept;
		logic mul;
		logic acc;
		logic blend;
		logic fin;
	} gso_cmd_t;

	// 10000*sin(pi/2 * q/2^qbits), odd polynomial in Q16, rounded and clamped.
	// Evaluated on constants only, to build the lookup table.
	function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned q,
			input int unsigned qbits);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		longint unsigned m;
		x  = longint'(q) << (16 - qbits);
		x2 = (x * x) >> 16;
		t  = 64'd11;
		t  = 64'd307    - ((x2 * t) >> 16);
		t  = 64'd5223   - ((x2 * t) >> 16);
		t  = 64'd42334  - ((x2 * t) >> 16);
		t  = 64'd102944 - ((x2 * t) >> 16);
		s  = (x * t) >> 16;
		m  = (s * 64'd10000 + 64'd32768) >> 16;
		if (m > 64'd10000)
			m = 64'd10000;
		return m[MAG_W-1:0];
	endfunction

endpackage

FILE: rtl/glide_sine_oscillator_core.sv
// Top level of the glide sine oscillator: ports, configuration registers, controller and datapath.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-------------------------------------------
//  s_axis   | s_axis_tvalid/s_axis_tready  | tdata[14:0] target_hz, [15] zero
//  m_axis   | m_axis_tvalid/m_axis_tready  | tdata[14:0] sample (signed), [15] zero
//  cfg      | cfg_valid/cfg_ready          | cfg_index, cfg_data
//
// A tick runs through accept, increment multiply, accumulate, glide multiply with
// table read, then the result register load; the two chained multiplies set this order.
// The next request is taken right after the result is loaded, even if it waits unread.
// A stalled m_axis holds the finished tick in its last step; nothing is dropped.
// Reset clears phase, loads the 440 Hz start frequency and empties the result register.
// cfg_ready is always high; indexes past the register list are ignored.
`timescale 1ns / 1ps
module glide_sine_oscillator_core #(
	parameter int PHASE_BITS      = gso_pkg::PHASE_BITS,
	parameter int SINE_TABLE_BITS = gso_pkg::SINE_TABLE_BITS,
	parameter int FREQ_FRAC_BITS  = gso_pkg::FREQ_FRAC_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [gso_pkg::TDATA_W-1:0]     s_axis_tdata,   // [14:0] target_hz
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [gso_pkg::TDATA_W-1:0]     m_axis_tdata,   // [14:0] sample
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gso_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gso_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import gso_pkg::*;

	logic [HZ_W-1:0]     initial_freq_q;
	logic [INCR_W-1:0]   phase_incr_q;
	logic                rectify_q;
	gso_cmd_t            cmd;
	logic [SAMPLE_W-1:0] sample;

	assign cfg_ready    = 1'b1;
	assign m_axis_tdata = {{(TDATA_W-SAMPLE_W){1'b0}}, sample};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_freq_q <= RST_INITIAL_FREQ;
			phase_incr_q   <= RST_PHASE_INCR;
			rectify_q      <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_INITIAL_FREQ: initial_freq_q <= cfg_data[HZ_W-1:0];
				CFG_PHASE_INCR:   phase_incr_q   <= cfg_data[INCR_W-1:0];
				CFG_RECTIFY:      rectify_q      <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	gso_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	gso_dp #(
		.PhaseBits     (PHASE_BITS),
		.SineTableBits (SINE_TABLE_BITS),
		.FreqFracBits  (FREQ_FRAC_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.target_hz         (s_axis_tdata[HZ_W-1:0]),
		.initial_freq      (initial_freq_q),
		.phase_incr_per_hz (phase_incr_q),
		.rectify           (rectify_q),
		.sample            (sample)
	);

endmodule

FILE: rtl/gso_ctrl.sv
// Sequencing state machine and output handshake for the glide sine oscillator.
`timescale 1ns / 1ps
module gso_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output gso_pkg::gso_cmd_t cmd
);
	import gso_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_BLEND,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   fin_go;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	// the result register must be empty or emptying before it is overwritten
	assign fin_go    = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		cmd        = '0;
		cmd.accept = in_valid && (state_q == ST_IDLE);
		cmd.mul    = (state_q == ST_MUL);
		cmd.acc    = (state_q == ST_ACC);
		cmd.blend  = (state_q == ST_BLEND);
		cmd.fin    = fin_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// a new result replaces one that leaves in the same cycle
			if (fin_go)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_MUL;
				end
				ST_MUL:   state_q <= ST_ACC;
				ST_ACC:   state_q <= ST_BLEND;
				ST_BLEND: state_q <= ST_FIN;
				ST_FIN: begin
					if (fin_go)
						state_q <= ST_IDLE;
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/gso_dp.sv
// Datapath: phase accumulator, frequency glide, sine lookup and result register.
`timescale 1ns / 1ps
module gso_dp #(
	parameter int PhaseBits     = gso_pkg::PHASE_BITS,
	parameter int SineTableBits = gso_pkg::SINE_TABLE_BITS,
	parameter int FreqFracBits  = gso_pkg::FREQ_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gso_pkg::gso_cmd_t             cmd,
	input  logic [gso_pkg::HZ_W-1:0]      target_hz,
	input  logic [gso_pkg::HZ_W-1:0]      initial_freq,
	input  logic [gso_pkg::INCR_W-1:0]    phase_incr_per_hz,
	input  logic                          rectify,
	output logic [gso_pkg::SAMPLE_W-1:0]  sample
);
	import gso_pkg::*;

	localparam int FW     = HZ_W + FreqFracBits;        // Q15.F frequency
	localparam int PW     = FW + INCR_W;                // frequency times step
	localparam int IW     = PW - FreqFracBits;          // step in accumulator units
	localparam int BW     = FW + PhaseBits + 2;         // signed glide product
	localparam int QB     = SineTableBits - 2;
	localparam int QDepth = (1 << QB) + 1;

	// quarter-wave table, folded to constants at elaboration
	logic [MAG_W-1:0] lut [QDepth];
	for (genvar i = 0; i < QDepth; i++) begin : g_lut
		assign lut[i] = quarter_sine(i, QB);
	end

	logic [FW-1:0]        cur_q;
	logic [FW-1:0]        target_q;
	logic                 loaded_q;
	logic [PhaseBits-1:0] phase_q;
	logic [PW-1:0]        incr_s1;
	logic signed [BW-1:0] glide_s2;
	logic [MAG_W-1:0]     mag_s2;
	logic                 neg_s2;
	logic [SAMPLE_W-1:0]  sample_q;

	logic [IW-1:0]              incr;
	logic signed [FW:0]         diff;
	logic [SineTableBits-1:0]   idx;
	logic [QB-1:0]              quad_pos;
	logic [QB:0]                qidx;
	logic [FW+1:0]              glide_hi;
	logic [FW-1:0]              cur_next;
	logic [SAMPLE_W-1:0]        mag_ext;

	assign incr   = incr_s1[PW-1:FreqFracBits];
	// cur*w + tgt*(2^P - w) == tgt*2^P + (cur - tgt)*w
	assign diff   = $signed({1'b0, cur_q}) - $signed({1'b0, target_q});
	assign idx    = phase_q[PhaseBits-1 -: SineTableBits];
	assign quad_pos = idx[QB-1:0];
	assign qidx   = idx[SineTableBits-2] ? (QB+1)'((1 << QB) - int'(quad_pos))
	                                     : {1'b0, quad_pos};
	assign glide_hi = glide_s2[BW-1:PhaseBits];
	assign cur_next = target_q + glide_hi[FW-1:0];
	assign mag_ext  = {{(SAMPLE_W-MAG_W){1'b0}}, mag_s2};
	assign sample   = sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q    <= FW'(RST_INITIAL_FREQ) << FreqFracBits;
			loaded_q <= 1'b0;
			phase_q  <= '0;
		end else begin
			if (cmd.accept && !loaded_q) begin
				cur_q    <= FW'(initial_freq) << FreqFracBits;
				loaded_q <= 1'b1;
			end
			if (cmd.acc)
				phase_q <= phase_q + PhaseBits'(incr);
			if (cmd.fin)
				cur_q <= cur_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept)
			target_q <= FW'(target_hz) << FreqFracBits;
		if (cmd.mul)
			incr_s1 <= PW'(cur_q) * PW'(phase_incr_per_hz);
		if (cmd.blend) begin
			glide_s2 <= BW'(diff) * BW'($signed({1'b0, phase_q}));
			mag_s2   <= lut[qidx];
			neg_s2   <= idx[SineTableBits-1];
		end
		if (cmd.fin)
			sample_q <= (neg_s2 && !rectify) ? (SAMPLE_W'(0) - mag_ext) : mag_ext;
	end

endmodule
